FILE: rtl/multi_slot_job_timer_macros.svh
// assertion macros for the multi-slot job timer
`ifndef MULTI_SLOT_JOB_TIMER_MACROS_SVH
`define MULTI_SLOT_JOB_TIMER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MJT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MJT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mjt_pkg.sv
// shared codes and types for the multi-slot job timer
`timescale 1ns / 1ps

package mjt_pkg;

	localparam logic [1:0] K_TICK   = 2'd0;
	localparam logic [1:0] K_ADD    = 2'd1;
	localparam logic [1:0] K_CANCEL = 2'd2;
	localparam logic [1:0] K_REAP   = 2'd3;

	localparam logic [1:0] COND_NONE      = 2'd0;
	localparam logic [1:0] COND_RUNNING   = 2'd1;
	localparam logic [1:0] COND_CANCELLED = 2'd2;
	localparam logic [1:0] COND_OVER      = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_NOSPACE   = 3'd2;
	localparam logic [2:0] ST_CANCELLED = 3'd3;
	localparam logic [2:0] ST_BUSY      = 3'd4;
	localparam logic [2:0] ST_RUNNING   = 3'd5;

	localparam int MAX_RESULTS = 16;
	localparam int SLOT_OUT_W  = 4;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic use_set;
		logic use_clr;
	} mem_ctl_t;

	typedef struct packed {
		logic       wr;
		logic       use_clr;
		logic       fire;
		logic [1:0] cond;
		logic [2:0] status;
	} unit_res_t;

endpackage

FILE: rtl/mjt_store.sv
// slot table storage: per-slot memory and in-use flags
`timescale 1ns / 1ps

module mjt_store
	import mjt_pkg::*;
#(
	parameter int SLOT_COUNT  = 16,
	parameter int PERIOD_BITS = 15
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  mem_ctl_t                                        ctl,
	input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
	input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_addr,
	input  logic [3+2*PERIOD_BITS-1:0]                      wr_data,
	output logic [3+2*PERIOD_BITS-1:0]                      rd_data,
	output logic [SLOT_COUNT-1:0]                           in_use
);

	localparam int EW = 3 + 2 * PERIOD_BITS;

	logic [EW-1:0] mem [SLOT_COUNT];
	logic [EW-1:0] rd_q;
	logic [SLOT_COUNT-1:0] in_use_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (ctl.use_set) begin
			in_use_q[wr_addr] <= 1'b1;
		end else if (ctl.use_clr) begin
			in_use_q[wr_addr] <= 1'b0;
		end
	end

	assign rd_data = rd_q;
	assign in_use  = in_use_q;

endmodule

FILE: rtl/mjt_unit.sv
// shared slot evaluation unit: countdown step, cancel and reap checks
`timescale 1ns / 1ps

module mjt_unit
	import mjt_pkg::*;
#(
	parameter int PERIOD_BITS = 15
) (
	input  logic [1:0]             op,
	input  logic                   use_ok,
	input  logic [1:0]             cond,
	input  logic                   rep,
	input  logic [PERIOD_BITS-1:0] period,
	input  logic [PERIOD_BITS-1:0] rem,
	output logic [PERIOD_BITS-1:0] nxt_rem,
	output unit_res_t              res
);

	logic                   act;
	logic [PERIOD_BITS-1:0] dec;

	assign act = use_ok && (cond == COND_RUNNING) && (rem != '0);
	assign dec = PERIOD_BITS'(rem - 1'b1);

	always_comb begin
		res         = '0;
		res.cond    = cond;
		res.status  = ST_OK;
		nxt_rem     = rem;
		unique case (op)
			K_TICK: begin
				res.wr   = act;
				nxt_rem  = dec;
				res.fire = act && (dec == '0);
				if (res.fire) begin
					if (rep) begin
						nxt_rem = period;
					end else begin
						res.cond = COND_OVER;
					end
				end
			end
			K_CANCEL: begin
				if (!use_ok) begin
					res.status = ST_INVALID;
				end else if (cond == COND_CANCELLED) begin
					res.status = ST_CANCELLED;
				end else if (cond == COND_OVER) begin
					res.status = ST_BUSY;
				end else begin
					res.wr   = 1'b1;
					res.cond = COND_CANCELLED;
				end
			end
			K_REAP: begin
				if (!use_ok) begin
					res.status = ST_INVALID;
				end else if (rep) begin
					res.status = ST_BUSY;
				end else if (cond == COND_RUNNING) begin
					res.status = ST_RUNNING;
				end else begin
					res.use_clr = 1'b1;
					res.cond    = COND_NONE;
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

endmodule

FILE: rtl/multi_slot_job_timer.sv
// top level of the multi-slot job timer: command sequencer and result register
// tick: one slot per cycle through the shared unit and the slot memory
// add: free-slot walk from slot 0; a negative period is answered from idle with no walk
// cancel and reap: memory read, then evaluate and write back
// results appear at most one per cycle on valid and cannot be stalled; busy is low when idle
// reset clears the sequencer and all in-use flags; slot contents are written by add
`timescale 1ns / 1ps

module multi_slot_job_timer
	import mjt_pkg::*;
#(
	parameter int SLOT_COUNT  = 16,
	parameter int PERIOD_BITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic signed [15:0]    period,
	input  logic                  repeating,
	input  logic [7:0]            slot_id,
	output logic                  valid,
	output logic [2:0]            status,
	output logic [SLOT_OUT_W-1:0] slot,
	output logic                  fired,
	output logic                  last
);

`include "multi_slot_job_timer_macros.svh"

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int EW = 3 + 2 * PERIOD_BITS;
	localparam int CW = $clog2(MAX_RESULTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
	localparam logic [31:0] PMAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_FIND = 6'b000010,
		S_LOOK = 6'b000100,
		S_EVAL = 6'b001000,
		S_TICK = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [1:0]             kind_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic                   rep_q;
	logic [7:0]             id_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          idx_s1;
	logic                   ev_s1;
	logic                   rdng_q;
	logic                   hold_q;
	logic [IW-1:0]          hold_slot_q;
	logic [CW-1:0]          cnt_q;

	logic                   valid_q;
	logic [2:0]             status_q;
	logic [SLOT_OUT_W-1:0]  slot_q;
	logic                   fired_q;
	logic                   last_q;

	logic                   emit;
	logic [2:0]             e_status;
	logic [SLOT_OUT_W-1:0]  e_slot;
	logic                   e_fired;
	logic                   e_last;

	logic [31:0]            p32;
	logic [31:0]            p_sat;
	logic [IW-1:0]          id_idx;
	logic                   id_ok;
	logic                   use_ok;
	logic                   fire_take;

	mem_ctl_t               ctl;
	logic [IW-1:0]          rd_addr;
	logic [IW-1:0]          wr_addr;
	logic [EW-1:0]          wr_data;
	logic [EW-1:0]          rd_data;
	logic [SLOT_COUNT-1:0]  in_use;

	logic [1:0]             r_cond;
	logic                   r_rep;
	logic [PERIOD_BITS-1:0] r_period;
	logic [PERIOD_BITS-1:0] r_rem;
	logic [PERIOD_BITS-1:0] nxt_rem;
	unit_res_t              ur;

	assign p32   = {16'd0, period};
	assign p_sat = (p32 > PMAX) ? PMAX : p32;

	assign id_idx = id_q[IW-1:0];
	assign id_ok  = (id_q < 8'(SLOT_COUNT)) && in_use[id_idx];
	assign use_ok = (state_q == S_TICK) ? in_use[idx_s1] : id_ok;

	assign {r_cond, r_rep, r_period, r_rem} = rd_data;

	mjt_store #(
		.SLOT_COUNT  (SLOT_COUNT),
		.PERIOD_BITS (PERIOD_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data),
		.in_use  (in_use)
	);

	mjt_unit #(
		.PERIOD_BITS (PERIOD_BITS)
	) u_unit (
		.op      (kind_q),
		.use_ok  (use_ok),
		.cond    (r_cond),
		.rep     (r_rep),
		.period  (r_period),
		.rem     (r_rem),
		.nxt_rem (nxt_rem),
		.res     (ur)
	);

	assign fire_take = ev_s1 && ur.fire && (cnt_q < CW'(MAX_RESULTS));

	always_comb begin
		ctl     = '0;
		rd_addr = idx_q;
		wr_addr = idx_q;
		wr_data = {ur.cond, r_rep, r_period, nxt_rem};
		state_d = state_q;
		emit     = 1'b0;
		e_status = ST_OK;
		e_slot   = '0;
		e_fired  = 1'b0;
		e_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (kind)
						K_TICK: state_d = S_TICK;
						K_ADD: begin
							if (period[15]) begin
								emit     = 1'b1;
								e_status = ST_INVALID;
							end else begin
								state_d = S_FIND;
							end
						end
						default: state_d = S_LOOK;
					endcase
				end
			end
			S_FIND: begin
				if (!in_use[idx_q]) begin
					ctl.wr_en   = 1'b1;
					ctl.use_set = 1'b1;
					wr_data     = {COND_RUNNING, rep_q, period_q, period_q};
					emit        = 1'b1;
					e_slot      = SLOT_OUT_W'(idx_q);
					state_d     = S_IDLE;
				end else if (idx_q == LAST_IDX) begin
					emit     = 1'b1;
					e_status = ST_NOSPACE;
					state_d  = S_IDLE;
				end
			end
			S_LOOK: begin
				ctl.rd_en = 1'b1;
				rd_addr   = id_idx;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				ctl.wr_en   = ur.wr;
				ctl.use_clr = ur.use_clr;
				wr_addr     = id_idx;
				emit        = 1'b1;
				e_status    = ur.status;
				state_d     = S_IDLE;
			end
			S_TICK: begin
				ctl.rd_en = rdng_q;
				rd_addr   = idx_q;
				wr_addr   = idx_s1;
				ctl.wr_en = ev_s1 && ur.wr;
				if (fire_take && hold_q) begin
					emit    = 1'b1;
					e_slot  = SLOT_OUT_W'(hold_slot_q);
					e_fired = 1'b1;
					e_last  = 1'b0;
				end
				if (ev_s1 && !rdng_q) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				emit    = 1'b1;
				e_slot  = hold_q ? SLOT_OUT_W'(hold_slot_q) : '0;
				e_fired = hold_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			ev_s1   <= 1'b0;
			rdng_q  <= 1'b0;
			hold_q  <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
			if (state_q == S_IDLE) begin
				idx_q  <= '0;
				ev_s1  <= 1'b0;
				rdng_q <= 1'b1;
				hold_q <= 1'b0;
				cnt_q  <= '0;
			end else if (state_q == S_FIND) begin
				idx_q <= IW'(idx_q + 1'b1);
			end else if (state_q == S_TICK) begin
				ev_s1 <= rdng_q;
				if (rdng_q) begin
					if (idx_q == LAST_IDX) begin
						rdng_q <= 1'b0;
					end else begin
						idx_q <= IW'(idx_q + 1'b1);
					end
				end
				if (fire_take) begin
					hold_q <= 1'b1;
					cnt_q  <= CW'(cnt_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q   <= kind;
			period_q <= p_sat[PERIOD_BITS-1:0];
			rep_q    <= repeating;
			id_q     <= slot_id;
		end
		if (state_q == S_TICK && rdng_q) begin
			idx_s1 <= idx_q;
		end
		if (fire_take) begin
			hold_slot_q <= idx_s1;
		end
		status_q <= e_status;
		slot_q   <= e_slot;
		fired_q  <= e_fired;
		last_q   <= e_last;
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign status = status_q;
	assign slot   = slot_q;
	assign fired  = fired_q;
	assign last   = last_q;

	`MJT_ASSERT_NOW(a_mid_result_busy, valid && !last, busy, "non-final result while idle")
	`MJT_ASSERT_NOW(a_fire_only_tick, valid && fired, kind_q == K_TICK, "fired result outside tick")
	`MJT_ASSERT_NOW(a_cnt_bound, busy, cnt_q <= CW'(MAX_RESULTS), "fire count past limit")
	`MJT_ASSERT_NEXT(a_tick_quiet, start && !busy && kind == K_TICK, !valid && busy, "tick answered early")

endmodule
